/* rtl/strmq_pkg.sv */
package strmq_pkg;

    localparam int LEAF_COUNT = 1024;
    localparam int NODE_DEPTH = 2 * LEAF_COUNT;
    localparam int ADDR_W     = $clog2(NODE_DEPTH);
    localparam int IDX_W      = ADDR_W + 1;
    localparam int POS_W      = 10;
    localparam int END_W      = 11;
    localparam int DATA_W     = 32;

    localparam logic signed [DATA_W-1:0] EMPTY_VAL = 32'sh7FFF_FFFF;

    typedef enum logic [1:0] {
        CMD_UPDATE = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_code_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_WRITE,
        ST_UPD_MERGE,
        ST_Q_READ,
        ST_Q_MERGE,
        ST_Q_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic upd_write;
        logic upd_merge;
        logic q_merge;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic upd_at_root;
        logic q_active;
    } dp_status_t;

    function automatic logic signed [DATA_W-1:0] smin(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        return (a <= b) ? a : b;
    endfunction

endpackage

/* rtl/segment_tree_range_min.sv */
// Channel   Handshake               Payload
// input     in_valid / in_ready     command, position, range_end, value
// output    out_valid / out_ready   minimum
//
// Update: per tree level, a write state (write node, read sibling) then a merge;
//   it walks leaf to root; the single node memory write port sets this split.
// Query: read and merge per level visited, then output; two node reads per level.
// Clear and reset: a sweep writes all 2048 nodes; no input taken then.
// A waiting result holds in the output register; a query stalls only at its end.
module segment_tree_range_min
    import strmq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               command,
    input  logic [POS_W-1:0]         position,
    input  logic [END_W-1:0]         range_end,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] minimum
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // controller sequences tree walks; datapath owns the node memory
    strmq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (cmd_code_t'(command)),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (dp_cmd),
        .status    (dp_status)
    );

    strmq_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .position  (position),
        .range_end (range_end),
        .value     (value),
        .minimum   (minimum)
    );

endmodule

/* rtl/strmq_datapath.sv */
module strmq_datapath
    import strmq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    output dp_status_t               status,
    input  logic [POS_W-1:0]         position,
    input  logic [END_W-1:0]         range_end,
    input  logic signed [DATA_W-1:0] value,
    output logic signed [DATA_W-1:0] minimum
);

    // heap numbering: root at 1, children 2k and 2k+1, leaf i at LEAF_COUNT+i
    logic signed [DATA_W-1:0] mem [NODE_DEPTH];

    logic [ADDR_W-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [ADDR_W-1:0]        k_reg, k_next;
    logic [IDX_W-1:0]         l_reg, l_next;
    logic [IDX_W-1:0]         r_reg, r_next;
    logic signed [DATA_W-1:0] cur_reg, cur_next;
    logic signed [DATA_W-1:0] res_reg, res_next;
    logic signed [DATA_W-1:0] min_reg, min_next;
    logic signed [DATA_W-1:0] rd_a_reg, rd_b_reg;

    logic [END_W-1:0]         end_clamp;
    logic [IDX_W-1:0]         r_dec;
    logic [ADDR_W-1:0]        rd_a_addr, rd_b_addr, wr_addr;
    logic                     wr_en;
    logic signed [DATA_W-1:0] wr_data;
    logic signed [DATA_W-1:0] take_l, take_r;

    assign end_clamp = (range_end > END_W'(LEAF_COUNT)) ? END_W'(LEAF_COUNT) : range_end;
    assign r_dec     = r_reg - IDX_W'(1);

    // port a: sibling during update, left edge during query; port b: right edge
    assign rd_a_addr = cmd.upd_write ? (k_reg ^ ADDR_W'(1)) : l_reg[ADDR_W-1:0];
    assign rd_b_addr = r_dec[ADDR_W-1:0];

    assign wr_en   = cmd.clr_step | cmd.upd_write;
    assign wr_addr = cmd.clr_step ? clr_cnt_reg : k_reg;
    assign wr_data = cmd.clr_step ? EMPTY_VAL : cur_reg;

    assign take_l = l_reg[0] ? rd_a_reg : EMPTY_VAL;
    assign take_r = r_reg[0] ? rd_b_reg : EMPTY_VAL;

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        k_next       = k_reg;
        l_next       = l_reg;
        r_next       = r_reg;
        cur_next     = cur_reg;
        res_next     = res_reg;
        min_next     = min_reg;
        if (cmd.load)
        begin
            clr_cnt_next = '0;
            k_next       = ADDR_W'(LEAF_COUNT) + ADDR_W'(position);
            l_next       = IDX_W'(LEAF_COUNT) + IDX_W'(position);
            r_next       = IDX_W'(LEAF_COUNT) + IDX_W'(end_clamp);
            cur_next     = value;
            res_next     = EMPTY_VAL;
        end
        if (cmd.clr_step)
        begin
            clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
        end
        if (cmd.upd_merge)
        begin
            cur_next = smin(cur_reg, rd_a_reg);
            k_next   = k_reg >> 1;
        end
        if (cmd.q_merge)
        begin
            res_next = smin(res_reg, smin(take_l, take_r));
            l_next   = (l_reg + IDX_W'(l_reg[0])) >> 1;
            r_next   = r_reg >> 1;
        end
        if (cmd.out_load)
        begin
            min_next = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        l_reg   <= l_next;
        r_reg   <= r_next;
        cur_reg <= cur_next;
        res_reg <= res_next;
        min_reg <= min_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    assign status.clr_last    = &clr_cnt_reg;
    assign status.upd_at_root = (k_reg == ADDR_W'(1));
    assign status.q_active    = (l_reg < r_reg);
    assign minimum            = min_reg;

`ifndef SYNTHESIS
    a_merge_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.q_merge |-> (l_reg < r_reg))
        else $error("query merge with empty window");

    a_upd_below_root: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd_merge |-> (k_reg > ADDR_W'(1)))
        else $error("update climbed past the root");
`endif

endmodule

/* rtl/strmq_ctrl.sv */
module strmq_ctrl
    import strmq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  cmd_code_t  command,
    output logic       out_valid,
    input  logic       out_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign accept = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (command)
                        CMD_UPDATE: state_next = ST_UPD_WRITE;
                        CMD_QUERY:  state_next = ST_Q_READ;
                        CMD_CLEAR:  state_next = ST_CLEAR;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_UPD_WRITE:
            begin
                state_next = status.upd_at_root ? ST_IDLE : ST_UPD_MERGE;
            end
            ST_UPD_MERGE:
            begin
                state_next = ST_UPD_WRITE;
            end
            ST_Q_READ:
            begin
                state_next = status.q_active ? ST_Q_MERGE : ST_Q_OUT;
            end
            ST_Q_MERGE:
            begin
                state_next = ST_Q_READ;
            end
            ST_Q_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:     cmd.clr_step  = 1'b1;
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_UPD_WRITE: cmd.upd_write = 1'b1;
            ST_UPD_MERGE: cmd.upd_merge = 1'b1;
            ST_Q_READ:    cmd.load      = 1'b0;
            ST_Q_MERGE:   cmd.q_merge   = 1'b1;
            ST_Q_OUT:     cmd.out_load  = !out_valid_reg || out_ready;
            default:      cmd           = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten before transaction");

    a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command == CMD_CLEAR) |=> (state_reg == ST_CLEAR))
        else $error("clear command did not start sweep");

    a_query_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_Q_OUT && state_next == ST_IDLE) |=> out_valid_reg)
        else $error("query finished without a result");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR || state_reg == ST_UPD_WRITE || state_reg == ST_Q_MERGE)
        |-> !in_ready)
        else $error("input taken while tree busy");
`endif

endmodule
